### hdl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the trapezoid pulse source.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  localparam int SF_WIDTH    = 17;
  localparam int SF_FRAC     = 16;
  localparam int PADDR_WIDTH = 6;
  localparam int PDATA_WIDTH = 64;
  localparam int IDX_LSB     = 3;
  localparam int IDX_WIDTH   = PADDR_WIDTH - IDX_LSB;
  localparam int CHUNK       = 16;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_AMPLITUDE   = 3'd0,
    REG_HIGH_TIME   = 3'd1,
    REG_LOW_TIME    = 3'd2,
    REG_RISE_TIME   = 3'd3,
    REG_FALL_TIME   = 3'd4,
    REG_START_DELAY = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_LOAD = 4'b0010,
    CS_MUL  = 4'b0100,
    CS_DIV  = 4'b1000
  } cfg_state_t;

endpackage

`default_nettype wire

### hdl/tps_ifs.sv
// ----------------------------------------------------------------------------
// tps interfaces
// Valid/ready channels for time points and current results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tps_sample_if #(
  parameter int TIME_WIDTH = 48
);
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] sim_time;
  logic [16:0]           source_factor;

  modport source (output valid, sim_time, source_factor, input ready);
  modport sink   (input valid, sim_time, source_factor, output ready);
endinterface

interface tps_result_if #(
  parameter int CURRENT_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic [CURRENT_WIDTH-1:0] pulse_current;
  logic [CURRENT_WIDTH-1:0] dc_level;

  modport source (output valid, pulse_current, dc_level, input ready);
  modport sink   (input valid, pulse_current, dc_level, output ready);
endinterface

`default_nettype wire

### hdl/tps_div_pipe.sv
// ----------------------------------------------------------------------------
// tps_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_div_pipe #(
  parameter int NW  = 48,
  parameter int DW  = 48,
  parameter int SH  = 0,
  parameter int QW  = 48,
  parameter int SBW = 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DW-1:0]  den,
  input  wire logic [SBW-1:0] side,
  output logic                out_valid,
  output logic [QW-1:0]       quo,
  output logic [NW-1:0]       rem,
  output logic [SBW-1:0]      side_out
);

  logic [NW-1:0]  rem_p  [QW];
  logic [QW-1:0]  quo_p  [QW];
  logic [DW-1:0]  den_p  [QW];
  logic [SBW-1:0] side_p [QW];
  logic           vld    [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int BIT = QW - 1 - k;
    logic [NW-1:0]  cur_rem;
    logic [QW-1:0]  cur_quo;
    logic [DW-1:0]  cur_den;
    logic [SBW-1:0] cur_side;
    logic           cur_v;
    logic           ge;

    if (k == 0) begin : g_first
      assign cur_rem  = num;
      assign cur_quo  = '0;
      assign cur_den  = den;
      assign cur_side = side;
      assign cur_v    = in_valid;
    end else begin : g_next
      assign cur_rem  = rem_p[k-1];
      assign cur_quo  = quo_p[k-1];
      assign cur_den  = den_p[k-1];
      assign cur_side = side_p[k-1];
      assign cur_v    = vld[k-1];
    end

    assign ge = (cur_rem >> (SH + BIT)) >= NW'(cur_den);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_p[k]  <= ge ? cur_rem - (NW'(cur_den) << (SH + BIT)) : cur_rem;
        quo_p[k]  <= cur_quo | (ge ? (QW'(1) << BIT) : QW'(0));
        den_p[k]  <= cur_den;
        side_p[k] <= cur_side;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = quo_p[QW-1];
  assign rem       = rem_p[QW-1];
  assign side_out  = side_p[QW-1];

endmodule

`default_nettype wire

### hdl/tps_cfg.sv
// ----------------------------------------------------------------------------
// tps_cfg
// Register file, derived pulse constants and sequential DC level unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_cfg
  import tps_pkg::*;
#(
  parameter int TIME_WIDTH    = 48,
  parameter int CURRENT_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_WIDTH-1:0]   paddr,
  input  wire logic [PDATA_WIDTH-1:0]   pwdata,
  output logic      [PDATA_WIDTH-1:0]   prdata,
  output logic                          pready,
  output logic                          busy,
  output logic      [CURRENT_WIDTH-1:0] mag,
  output logic                          neg,
  output logic      [TIME_WIDTH-2:0]    rise_c,
  output logic      [TIME_WIDTH-2:0]    fall_c,
  output logic      [TIME_WIDTH-2:0]    high,
  output logic      [TIME_WIDTH-1:0]    fall_end,
  output logic      [TIME_WIDTH-1:0]    period,
  output logic      [TIME_WIDTH-1:0]    delay,
  output logic      [CURRENT_WIDTH-1:0] dc
);

  localparam int CW   = CURRENT_WIDTH;
  localparam int FW   = TIME_WIDTH - 1;
  localparam int KW   = TIME_WIDTH + 1;
  localparam int NUMW = CURRENT_WIDTH + TIME_WIDTH + 1;
  localparam int CNTW = $clog2((KW > CW) ? KW : CW);
  localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};

  logic [CW-1:0]         amplitude;
  logic [FW-1:0]         high_time;
  logic [FW-1:0]         low_time;
  logic [FW-1:0]         rise_time;
  logic [FW-1:0]         fall_time;
  logic [TIME_WIDTH-1:0] start_delay;

  cfg_state_t            state;
  logic [CNTW-1:0]       cnt;
  logic [NUMW-1:0]       acc;
  logic [NUMW-1:0]       mcand;
  logic [NUMW-1:0]       dsr;
  logic [KW-1:0]         mplier;
  logic [CW-1:0]         quot;

  logic                  wr;
  reg_idx_t              widx;
  logic [FW-1:0]         tr_w;
  logic [FW-1:0]         tf_w;
  logic [CW-1:0]         mag_w;
  logic [KW-1:0]         k_w;
  logic [NUMW-1:0]       acc_next;
  logic                  ge;
  logic [CW-1:0]         quot_next;
  logic [CW-1:0]         lim;
  logic [CW-1:0]         quot_sat;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[PADDR_WIDTH-1:IDX_LSB]);
  assign busy   = (state != CS_IDLE);
  assign delay  = start_delay;

  always_comb begin
    case (widx)
      REG_AMPLITUDE:   prdata = PDATA_WIDTH'(amplitude);
      REG_HIGH_TIME:   prdata = PDATA_WIDTH'(high_time);
      REG_LOW_TIME:    prdata = PDATA_WIDTH'(low_time);
      REG_RISE_TIME:   prdata = PDATA_WIDTH'(rise_time);
      REG_FALL_TIME:   prdata = PDATA_WIDTH'(fall_time);
      REG_START_DELAY: prdata = PDATA_WIDTH'(start_delay);
      default:         prdata = '0;
    endcase
  end

  assign tr_w      = (rise_time > high_time) ? high_time : rise_time;
  assign tf_w      = (fall_time > low_time) ? low_time : fall_time;
  assign mag_w     = amplitude[CW-1] ? (CW'(0) - amplitude) : amplitude;
  assign k_w       = KW'({high_time, 1'b0}) - KW'(tr_w) + KW'(tf_w);
  assign acc_next  = acc + (mplier[0] ? mcand : NUMW'(0));
  assign ge        = acc >= dsr;
  assign quot_next = {quot[CW-2:0], ge};
  assign lim       = LIM_POS + CW'(neg);
  assign quot_sat  = (quot_next > lim) ? lim : quot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude   <= CW'(1000000);
      high_time   <= FW'(1000000);
      low_time    <= FW'(1000000);
      rise_time   <= FW'(1);
      fall_time   <= FW'(1);
      start_delay <= '0;
      state       <= CS_LOAD;
      cnt         <= '0;
    end else if (wr) begin
      case (widx)
        REG_AMPLITUDE:   amplitude   <= pwdata[CW-1:0];
        REG_HIGH_TIME:   high_time   <= pwdata[FW-1:0];
        REG_LOW_TIME:    low_time    <= pwdata[FW-1:0];
        REG_RISE_TIME:   rise_time   <= pwdata[FW-1:0];
        REG_FALL_TIME:   fall_time   <= pwdata[FW-1:0];
        REG_START_DELAY: start_delay <= pwdata[TIME_WIDTH-1:0];
        default: ;
      endcase
      state <= CS_LOAD;
      cnt   <= '0;
    end else begin
      case (state)
        CS_LOAD: begin
          state <= CS_MUL;
          cnt   <= '0;
        end
        CS_MUL: begin
          if (cnt == CNTW'(KW - 1)) begin
            state <= CS_DIV;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        CS_DIV: begin
          if (cnt == CNTW'(CW - 1)) begin
            state <= CS_IDLE;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        default: state <= CS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CS_LOAD: begin
        rise_c   <= tr_w;
        fall_c   <= tf_w;
        high     <= high_time;
        fall_end <= TIME_WIDTH'(high_time) + TIME_WIDTH'(tf_w);
        period   <= TIME_WIDTH'(high_time) + TIME_WIDTH'(low_time);
        mag      <= mag_w;
        neg      <= amplitude[CW-1];
        mcand    <= NUMW'(mag_w);
        mplier   <= k_w;
        acc      <= '0;
      end
      CS_MUL: begin
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        if (cnt == CNTW'(KW - 1)) begin
          acc  <= acc_next + NUMW'(period);
          dsr  <= NUMW'({period, 1'b0}) << (CW - 1);
          quot <= '0;
        end else begin
          acc <= acc_next;
        end
      end
      CS_DIV: begin
        acc  <= ge ? acc - dsr : acc;
        dsr  <= dsr >> 1;
        quot <= quot_next;
        if (cnt == CNTW'(CW - 1)) begin
          if (period == '0) begin
            dc <= '0;
          end else begin
            dc <= neg ? (CW'(0) - quot_sat) : quot_sat;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hdl/trapezoid_pulse_source_unit.sv
// ----------------------------------------------------------------------------
// trapezoid_pulse_source_unit
// Trapezoidal pulse current source, evaluated at one time point per item.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the result channel stalls or the DC level
// unit is busy, and returns one result per item, in order. Stages: one input
// stage, a TIME_WIDTH-stage divider for the phase within the period, phase
// select, partial products, sum, a (CURRENT_WIDTH + 1)-stage divider for the
// rounded current, and the output register. The DC level is worked out by a
// shift-add multiplier and restoring divider after reset and after every
// register write; while it is worked out the sample channel is not ready.
`default_nettype none

module trapezoid_pulse_source_unit
  import tps_pkg::*;
#(
  parameter int TIME_WIDTH    = 48,
  parameter int CURRENT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  tps_sample_if.sink                  sample,
  tps_result_if.source                result,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_WIDTH-1:0] paddr,
  input  wire logic [PDATA_WIDTH-1:0] pwdata,
  output logic      [PDATA_WIDTH-1:0] prdata,
  output logic                        pready
);

  localparam int TW  = TIME_WIDTH;
  localparam int CW  = CURRENT_WIDTH;
  localparam int FW  = TW - 1;
  localparam int MW  = CW + SF_WIDTH;
  localparam int NCH = (FW + CHUNK - 1) / CHUNK;
  localparam int PW  = MW + CHUNK;
  localparam int NW  = CW + TW + SF_FRAC;
  localparam int QW  = CW + 1;
  localparam logic [QW-1:0] LIM_POS = QW'({1'b0, {(CW-1){1'b1}}});

  logic          busy;
  logic [CW-1:0] mag;
  logic          neg;
  logic [FW-1:0] rise_c;
  logic [FW-1:0] fall_c;
  logic [FW-1:0] high;
  logic [TW-1:0] fall_end;
  logic [TW-1:0] period;
  logic [TW-1:0] delay;
  logic [CW-1:0] dc;

  tps_cfg #(
    .TIME_WIDTH    (TW),
    .CURRENT_WIDTH (CW)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .busy     (busy),
    .mag      (mag),
    .neg      (neg),
    .rise_c   (rise_c),
    .fall_c   (fall_c),
    .high     (high),
    .fall_end (fall_end),
    .period   (period),
    .delay    (delay),
    .dc       (dc)
  );

  logic en;
  logic take;

  logic          o_v;
  logic [CW-1:0] o_cur;

  assign en           = !o_v || result.ready;
  assign sample.ready = en && !busy;
  assign take         = sample.valid && sample.ready;

  // input stage
  logic          a_v;
  logic          a_after;
  logic [TW-1:0] a_diff;
  logic [MW-1:0] a_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_after <= $signed(sample.sim_time) > $signed(delay);
      a_diff  <= sample.sim_time - delay;
      a_ms    <= MW'(mag) * MW'(sample.source_factor);
    end
  end

  // phase within the period
  logic          m_v;
  logic [TW-1:0] m_ph;
  logic [MW:0]   m_side;

  tps_div_pipe #(
    .NW  (TW),
    .DW  (TW),
    .SH  (0),
    .QW  (TW),
    .SBW (MW + 1)
  ) u_phase_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (a_v),
    .num       (a_diff),
    .den       (period),
    .side      ({a_after, a_ms}),
    .out_valid (m_v),
    .quo       (),
    .rem       (m_ph),
    .side_out  (m_side)
  );

  // phase select
  logic          live_c;
  logic [FW-1:0] fa_c;
  logic [FW-1:0] fb_c;

  always_comb begin
    live_c = 1'b1;
    fa_c   = '0;
    fb_c   = FW'(1);
    if (m_ph < TW'(rise_c)) begin
      fa_c = m_ph[FW-1:0];
      fb_c = rise_c;
    end else if (m_ph < TW'(high)) begin
      fa_c = FW'(1);
    end else if (m_ph < fall_end) begin
      fa_c = FW'(fall_end - m_ph);
      fb_c = fall_c;
    end else begin
      live_c = 1'b0;
    end
    if (!m_side[MW] || period == '0) begin
      live_c = 1'b0;
      fa_c   = '0;
      fb_c   = FW'(1);
    end
  end

  logic                   p_v;
  logic                   p_live;
  logic [NCH*CHUNK-1:0]   p_fa;
  logic [FW-1:0]          p_fb;
  logic [MW-1:0]          p_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_live <= live_c;
      p_fa   <= (NCH*CHUNK)'(fa_c);
      p_fb   <= fb_c;
      p_ms   <= m_side[MW-1:0];
    end
  end

  // partial products
  logic          x_v;
  logic          x_live;
  logic [FW-1:0] x_fb;
  logic [PW-1:0] x_pp [NCH];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_v <= 1'b0;
    end else if (en) begin
      x_v <= p_v;
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) begin
        x_pp[c] <= PW'(p_ms) * PW'(p_fa[c*CHUNK +: CHUNK]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_live <= p_live;
      x_fb   <= p_fb;
    end
  end

  // sum and rounding offset
  logic [NW-1:0] sum_c;

  always_comb begin
    sum_c = NW'(x_fb) << (SF_FRAC - 1);
    for (int c = 0; c < NCH; c++) begin
      sum_c = sum_c + (NW'(x_pp[c]) << (c * CHUNK));
    end
  end

  logic          s_v;
  logic          s_live;
  logic [NW-1:0] s_num;
  logic [FW-1:0] s_fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (en) begin
      s_v <= x_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_live <= x_live;
      s_num  <= sum_c;
      s_fb   <= x_fb;
    end
  end

  // rounded quotient
  logic          q_v;
  logic [QW-1:0] q_quo;
  logic          q_live;

  tps_div_pipe #(
    .NW  (NW),
    .DW  (FW),
    .SH  (SF_FRAC),
    .QW  (QW),
    .SBW (1)
  ) u_cur_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_v),
    .num       (s_num),
    .den       (s_fb),
    .side      (s_live),
    .out_valid (q_v),
    .quo       (q_quo),
    .rem       (),
    .side_out  (q_live)
  );

  // saturate, sign and output register
  logic [QW-1:0] lim;
  logic [QW-1:0] q_sat;

  assign lim   = LIM_POS + QW'(neg);
  assign q_sat = (q_quo > lim) ? lim : q_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en) begin
      o_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!q_live) begin
        o_cur <= '0;
      end else begin
        o_cur <= neg ? (CW'(0) - q_sat[CW-1:0]) : q_sat[CW-1:0];
      end
    end
  end

  assign result.valid         = o_v;
  assign result.pulse_current = o_cur;
  assign result.dc_level      = dc;

endmodule

`default_nettype wire
